// ----- rtl/acl_permission_table_macros.svh -----
// assertion helpers for the acl permission table
`ifndef ACL_PERMISSION_TABLE_MACROS_SVH
`define ACL_PERMISSION_TABLE_MACROS_SVH

// same-cycle implication
`define ACLPT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ACLPT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/aclpt_pkg.sv -----
`timescale 1ns / 1ps
package aclpt_pkg;

	localparam int ENTRIES_DEF = 64;

	localparam logic [1:0] OP_CHECK   = 2'd0;
	localparam logic [1:0] OP_SET_XOR = 2'd1;
	localparam logic [1:0] OP_SET_OR  = 2'd2;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_ACCES = 3'd1;
	localparam logic [2:0] ST_PERM  = 3'd2;
	localparam logic [2:0] ST_ROFS  = 3'd3;
	localparam logic [2:0] ST_FULL  = 3'd4;

	localparam logic [15:0] ID_UNKNOWN  = 16'hFFFF;
	localparam logic [15:0] ROOT_UID    = 16'h0000;
	localparam logic [3:0]  MODE_DIR    = 4'h4;
	localparam logic [15:0] MODE_X_MASK = 16'h0049;
	localparam logic [2:0]  PERM_W      = 3'b010;
	localparam logic [2:0]  PERM_RWX    = 3'b111;
	localparam logic [2:0]  PERM_RW     = 3'b110;

	typedef struct packed {
		logic [31:0] inode;
		logic        kind;
		logic [15:0] id;
		logic [2:0]  bits;
	} entry_t;

	function automatic logic [2:0] chk_status(input logic [2:0] allowed,
		input logic [2:0] want, input logic ro);
		logic [2:0] st;
		if ((allowed | want) != allowed) begin
			st = ST_ACCES;
		end else if (((want & PERM_W) != 3'b000) && ro) begin
			st = ST_ROFS;
		end else begin
			st = ST_OK;
		end
		return st;
	endfunction

endpackage

// ----- rtl/aclpt_if.sv -----
`timescale 1ns / 1ps
interface aclpt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [31:0] inode;
	logic [15:0] file_mode;
	logic [15:0] owner_uid;
	logic [15:0] owner_gid;
	logic [15:0] caller_uid;
	logic [15:0] caller_gid;
	logic        in_supp_group;
	logic        readonly_fs;
	logic [2:0]  perms;
	logic        acl_kind;
	logic [15:0] acl_id;

	modport source (output valid, op, inode, file_mode, owner_uid, owner_gid, caller_uid,
		caller_gid, in_supp_group, readonly_fs, perms, acl_kind, acl_id, input ready);
	modport sink (input valid, op, inode, file_mode, owner_uid, owner_gid, caller_uid,
		caller_gid, in_supp_group, readonly_fs, perms, acl_kind, acl_id, output ready);
endinterface

interface aclpt_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [2:0] granted;
	logic       entry_found;

	modport source (output valid, status, granted, entry_found, input ready);
	modport sink (input valid, status, granted, entry_found, output ready);
endinterface

// ----- rtl/aclpt_mem.sv -----
`timescale 1ns / 1ps
module aclpt_mem #(
	parameter int ENTRIES = aclpt_pkg::ENTRIES_DEF,
	parameter int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic               clk,
	input  logic               we,
	input  logic [IDX_W-1:0]   waddr,
	input  aclpt_pkg::entry_t  wdata,
	input  logic               re,
	input  logic [IDX_W-1:0]   raddr,
	output aclpt_pkg::entry_t  rdata
);

	aclpt_pkg::entry_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/acl_permission_table.sv -----
`timescale 1ns / 1ps
// acl permission table
// req channel: one word per access check (op 0) or acl update (op 1 xor, op 2/3 or).
// rsp channel: exactly one word per request: status, granted rwx bits, entry_found.
// the acl table sits in one single-port-read memory of ENTRIES words, one read per
// cycle with registered read data; the scan walks entries 0..count-1 in order
// and stops at the first match.
// early outcomes (unknown owner, root check, not permitted, read-only set) go from
// the start state straight to done; a scan runs in the scan state, and an update
// adds a memory write state (merge into the hit entry, or append if not full).
// one request is in work at a time: req.ready is high only in the idle state.
// rsp is held in an output register; the next request is taken while a finished
// word still waits there, and a further result waits in the block until the
// receiver takes the previous one (req.ready stays low meanwhile).
// reset clears the entry count and all control; table contents need no clearing.
`include "acl_permission_table_macros.svh"
module acl_permission_table #(
	parameter int ENTRIES = aclpt_pkg::ENTRIES_DEF
) (
	input logic          clk,
	input logic          arst_n,
	aclpt_req_if.sink    req,
	aclpt_rsp_if.source  rsp
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_WRITE = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] issue_q;
	logic rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic out_vld_q;

	logic [1:0]  op_q;
	logic [31:0] inode_q;
	logic [15:0] mode_q;
	logic [15:0] ouid_q;
	logic [15:0] ogid_q;
	logic [15:0] cuid_q;
	logic [15:0] cgid_q;
	logic        supp_q;
	logic        ro_q;
	logic [2:0]  perms_q;
	logic        kind_q;
	logic [15:0] id_q;

	logic [2:0] res_status_q;
	logic [2:0] res_granted_q;
	logic       res_found_q;
	logic [2:0] out_status_q;
	logic [2:0] out_granted_q;
	logic       out_found_q;
	logic [IDX_W-1:0] wr_idx_q;
	aclpt_pkg::entry_t wr_word_q;
	logic app_q;

	aclpt_pkg::entry_t rd;
	logic is_set;
	logic use_or;
	logic unknown_id;
	logic is_root;
	logic may_set;
	logic [2:0] base_allowed;
	logic [2:0] root_allowed;
	logic [2:0] hit_allowed;
	logic [2:0] merged;
	logic chk_hit;
	logic set_hit;
	logic hit;
	logic scan_end;
	logic full;
	logic slot_free;
	logic mem_re;

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_vld_q;
	assign rsp.status = out_status_q;
	assign rsp.granted = out_granted_q;
	assign rsp.entry_found = out_found_q;

	assign is_set = (op_q != aclpt_pkg::OP_CHECK);
	// bit 1 selects or-merge, op 3 included
	assign use_or = op_q[1];
	assign unknown_id = (ouid_q == aclpt_pkg::ID_UNKNOWN) || (ogid_q == aclpt_pkg::ID_UNKNOWN);
	assign is_root = (cuid_q == aclpt_pkg::ROOT_UID);
	assign may_set = (ouid_q == cuid_q) || is_root;

	always_comb begin
		if (cuid_q == ouid_q) begin
			base_allowed = mode_q[8:6];
		end else if ((cgid_q == ogid_q) || supp_q) begin
			base_allowed = mode_q[5:3];
		end else begin
			base_allowed = mode_q[2:0];
		end
	end

	assign root_allowed = ((mode_q[15:12] == aclpt_pkg::MODE_DIR) ||
		((mode_q & aclpt_pkg::MODE_X_MASK) != 16'h0000)) ? aclpt_pkg::PERM_RWX
		: aclpt_pkg::PERM_RW;

	assign hit_allowed = base_allowed | rd.bits;
	assign merged = use_or ? (perms_q | rd.bits) : (perms_q ^ rd.bits);
	assign chk_hit = (rd.inode == inode_q) && (rd.id == (rd.kind ? cuid_q : cgid_q));
	assign set_hit = (rd.inode == inode_q) && (rd.kind == kind_q) && (rd.id == id_q);
	assign hit = rd_vld_s1 && (is_set ? set_hit : chk_hit);
	assign scan_end = (issue_q == cnt_q);
	assign full = (cnt_q == CNT_W'(ENTRIES));
	assign slot_free = !out_vld_q || rsp.ready;
	assign mem_re = (state_q == S_SCAN) && !scan_end;

	aclpt_mem #(
		.ENTRIES(ENTRIES),
		.IDX_W(IDX_W)
	) u_mem (
		.clk(clk),
		.we(state_q == S_WRITE),
		.waddr(wr_idx_q),
		.wdata(wr_word_q),
		.re(mem_re),
		.raddr(issue_q[IDX_W-1:0]),
		.rdata(rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			issue_q <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && slot_free) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					issue_q <= '0;
					rd_vld_s1 <= 1'b0;
					if (!is_set) begin
						state_q <= (unknown_id || is_root) ? S_DONE : S_SCAN;
					end else begin
						state_q <= (!may_set || ro_q) ? S_DONE : S_SCAN;
					end
				end
				S_SCAN: begin
					rd_vld_s1 <= mem_re && !hit;
					if (mem_re) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (hit) begin
						state_q <= is_set ? S_WRITE : S_DONE;
					end else if (scan_end) begin
						state_q <= (is_set && !full) ? S_WRITE : S_DONE;
					end
				end
				S_WRITE: begin
					if (app_q) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_idx_s1 <= issue_q[IDX_W-1:0];
		end
		if (req.valid && req.ready) begin
			op_q <= req.op;
			inode_q <= req.inode;
			mode_q <= req.file_mode;
			ouid_q <= req.owner_uid;
			ogid_q <= req.owner_gid;
			cuid_q <= req.caller_uid;
			cgid_q <= req.caller_gid;
			supp_q <= req.in_supp_group;
			ro_q <= req.readonly_fs;
			perms_q <= req.perms;
			kind_q <= req.acl_kind;
			id_q <= req.acl_id;
		end
		unique case (state_q)
			S_START: begin
				res_found_q <= 1'b0;
				if (!is_set && !unknown_id) begin
					res_status_q <= aclpt_pkg::chk_status(root_allowed, perms_q, ro_q);
					res_granted_q <= root_allowed;
				end else begin
					res_granted_q <= 3'b000;
					if (!is_set) begin
						res_status_q <= aclpt_pkg::ST_ACCES;
					end else begin
						res_status_q <= !may_set ? aclpt_pkg::ST_PERM : aclpt_pkg::ST_ROFS;
					end
				end
			end
			S_SCAN: begin
				if (hit) begin
					res_found_q <= 1'b1;
					app_q <= 1'b0;
					wr_idx_q <= rd_idx_s1;
					wr_word_q <= '{inode: rd.inode, kind: rd.kind, id: rd.id, bits: merged};
					if (is_set) begin
						res_status_q <= aclpt_pkg::ST_OK;
						res_granted_q <= merged;
					end else begin
						res_status_q <= aclpt_pkg::chk_status(hit_allowed, perms_q, ro_q);
						res_granted_q <= hit_allowed;
					end
				end else if (scan_end) begin
					res_found_q <= 1'b0;
					app_q <= 1'b1;
					wr_idx_q <= cnt_q[IDX_W-1:0];
					wr_word_q <= '{inode: inode_q, kind: kind_q, id: id_q, bits: perms_q};
					if (is_set) begin
						res_status_q <= full ? aclpt_pkg::ST_FULL : aclpt_pkg::ST_OK;
						res_granted_q <= full ? 3'b000 : perms_q;
					end else begin
						res_status_q <= aclpt_pkg::chk_status(base_allowed, perms_q, ro_q);
						res_granted_q <= base_allowed;
					end
				end
			end
			S_DONE: begin
				if (slot_free) begin
					out_status_q <= res_status_q;
					out_granted_q <= res_granted_q;
					out_found_q <= res_found_q;
				end
			end
			default: begin
			end
		endcase
	end

	`ACLPT_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(ENTRIES), "entry count above table size")
	`ACLPT_ASSERT_NXT(a_cnt_hold, state_q != S_WRITE, cnt_q == $past(cnt_q), "count moved outside write")
	`ACLPT_ASSERT_NXT(a_cnt_app, (state_q == S_WRITE) && app_q, cnt_q == $past(cnt_q) + CNT_W'(1), "append lost")
	`ACLPT_ASSERT_IMP(a_rd_valid, rd_vld_s1, CNT_W'(rd_idx_s1) < cnt_q, "read of unwritten entry")

endmodule

// ----- dv/acl_verdict_checker.sv -----
`timescale 1ns / 1ps
module acl_verdict_checker #(
	parameter int ENTRIES = aclpt_pkg::ENTRIES_DEF
) (
	input logic   clk,
	input logic   arst_n,
	aclpt_req_if  req,
	aclpt_rsp_if  rsp,
	output int    mismatches,
	output int    outstanding
);

	typedef struct packed {
		logic [2:0] status;
		logic [2:0] granted;
		logic       found;
	} verdict_t;

	aclpt_pkg::entry_t acl_tab [ENTRIES];
	int       acl_used;
	verdict_t verdict_q [$];

	// works out the answer to the request word on the channel and updates the table copy
	function automatic verdict_t judge_word();
		verdict_t   v;
		logic [2:0] allowed;
		logic [15:0] who;
		bit         hit;
		v = '0;
		hit = 1'b0;
		if (req.op == aclpt_pkg::OP_CHECK) begin
			if (req.owner_uid == aclpt_pkg::ID_UNKNOWN ||
				req.owner_gid == aclpt_pkg::ID_UNKNOWN) begin
				v.status = aclpt_pkg::ST_ACCES;
			end else begin
				if (req.caller_uid == aclpt_pkg::ROOT_UID) begin
					if (req.file_mode[15:12] == aclpt_pkg::MODE_DIR ||
						(req.file_mode & aclpt_pkg::MODE_X_MASK) != '0) begin
						allowed = aclpt_pkg::PERM_RWX;
					end else begin
						allowed = aclpt_pkg::PERM_RW;
					end
				end else begin
					if (req.caller_uid == req.owner_uid) begin
						allowed = req.file_mode[8:6];
					end else if (req.caller_gid == req.owner_gid || req.in_supp_group) begin
						allowed = req.file_mode[5:3];
					end else begin
						allowed = req.file_mode[2:0];
					end
					for (int i = 0; i < acl_used && !hit; i++) begin
						who = acl_tab[i].kind ? req.caller_uid : req.caller_gid;
						if (acl_tab[i].inode == req.inode && acl_tab[i].id == who) begin
							allowed = allowed | acl_tab[i].bits;
							hit = 1'b1;
						end
					end
				end
				v.granted = allowed;
				v.found = hit;
				if ((allowed | req.perms) != allowed) begin
					v.status = aclpt_pkg::ST_ACCES;
				end else if ((req.perms & aclpt_pkg::PERM_W) != '0 && req.readonly_fs) begin
					v.status = aclpt_pkg::ST_ROFS;
				end else begin
					v.status = aclpt_pkg::ST_OK;
				end
			end
		end else if (req.caller_uid != req.owner_uid && req.caller_uid != aclpt_pkg::ROOT_UID) begin
			v.status = aclpt_pkg::ST_PERM;
		end else if (req.readonly_fs) begin
			v.status = aclpt_pkg::ST_ROFS;
		end else begin
			for (int i = 0; i < acl_used && !hit; i++) begin
				if (acl_tab[i].inode == req.inode && acl_tab[i].kind == req.acl_kind &&
					acl_tab[i].id == req.acl_id) begin
					// op bit 1 selects or, else xor
					if (req.op[1]) begin
						acl_tab[i].bits = acl_tab[i].bits | req.perms;
					end else begin
						acl_tab[i].bits = acl_tab[i].bits ^ req.perms;
					end
					v.status = aclpt_pkg::ST_OK;
					v.granted = acl_tab[i].bits;
					v.found = 1'b1;
					hit = 1'b1;
				end
			end
			if (!hit) begin
				if (acl_used >= ENTRIES) begin
					v.status = aclpt_pkg::ST_FULL;
				end else begin
					acl_tab[acl_used] = '{inode: req.inode, kind: req.acl_kind,
						id: req.acl_id, bits: req.perms};
					acl_used++;
					v.status = aclpt_pkg::ST_OK;
					v.granted = req.perms;
				end
			end
		end
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		verdict_t got;
		verdict_t want;
		if (!arst_n) begin
			acl_used = 0;
			verdict_q.delete();
			outstanding = 0;
			mismatches = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got = '{status: rsp.status, granted: rsp.granted, found: rsp.entry_found};
				if (verdict_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: result word with none expected: status %0d granted %0o found %0d",
							$realtime, got.status, got.granted, got.found);
					end
				end else begin
					want = verdict_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: mismatch: status %0d/%0d granted %0o/%0o found %0d/%0d",
								$realtime, want.status, got.status, want.granted, got.granted,
								want.found, got.found);
						end
					end
				end
			end
			if (req.valid && req.ready) begin
				verdict_q.push_back(judge_word());
			end
			outstanding = verdict_q.size();
		end
	end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

	localparam logic [1:0] OP_CHECK = aclpt_pkg::OP_CHECK;
	localparam logic [1:0] OP_SET_XOR = aclpt_pkg::OP_SET_XOR;
	localparam logic [1:0] OP_SET_OR = aclpt_pkg::OP_SET_OR;
	localparam logic [1:0] OP_SET_ALT = 2'd3;
	localparam logic [15:0] ID_UNKNOWN = aclpt_pkg::ID_UNKNOWN;
	localparam logic [15:0] ROOT_UID = aclpt_pkg::ROOT_UID;
	localparam int LONG_HOLD = 300;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] inode;
		logic [15:0] file_mode;
		logic [15:0] owner_uid;
		logic [15:0] owner_gid;
		logic [15:0] caller_uid;
		logic [15:0] caller_gid;
		logic        in_supp_group;
		logic        readonly_fs;
		logic [2:0]  perms;
		logic        acl_kind;
		logic [15:0] acl_id;
	} acl_word_t;

	logic clk = 1'b0;
	logic arst_n;
	bit   idle_on;
	int   stall_asks;
	int   stall_seen;
	int   mismatches;
	int   outstanding;

	logic [31:0] inode_pool [8];
	logic [15:0] uid_pool [6];
	logic [15:0] gid_pool [6];

	aclpt_req_if req_ch ();
	aclpt_rsp_if rsp_ch ();

	acl_permission_table u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	acl_verdict_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#6_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver side: random back-pressure while idle_on is set, plus one long hold when asked
	initial begin
		rsp_ch.ready = 1'b0;
		stall_seen = 0;
		forever begin
			@(negedge clk);
			if (stall_asks != stall_seen) begin
				stall_seen = stall_asks;
				rsp_ch.ready <= 1'b0;
				for (int n = 1; n < LONG_HOLD; n++) begin
					@(negedge clk);
				end
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(0, 7)) @(negedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	function automatic acl_word_t mk_word(logic [1:0] op, logic [31:0] inode,
		logic [15:0] mode, logic [15:0] ouid, logic [15:0] ogid, logic [15:0] cuid,
		logic [15:0] cgid, logic supp, logic ro, logic [2:0] perms, logic kind,
		logic [15:0] id);
		acl_word_t w;
		w.op = op;
		w.inode = inode;
		w.file_mode = mode;
		w.owner_uid = ouid;
		w.owner_gid = ogid;
		w.caller_uid = cuid;
		w.caller_gid = cgid;
		w.in_supp_group = supp;
		w.readonly_fs = ro;
		w.perms = perms;
		w.acl_kind = kind;
		w.acl_id = id;
		return w;
	endfunction

	function automatic acl_word_t random_word();
		acl_word_t w;
		int r;
		if ($urandom_range(0, 99) < 15) begin
			// noise over the whole field ranges
			w.op = 2'($urandom_range(0, 3));
			w.inode = $urandom;
			w.file_mode = 16'($urandom_range(0, 65535));
			w.owner_uid = 16'($urandom_range(0, 65535));
			w.owner_gid = 16'($urandom_range(0, 65535));
			w.caller_uid = 16'($urandom_range(0, 65535));
			w.caller_gid = 16'($urandom_range(0, 65535));
			w.in_supp_group = 1'($urandom_range(0, 1));
			w.readonly_fs = 1'($urandom_range(0, 1));
			w.perms = 3'($urandom_range(0, 7));
			w.acl_kind = 1'($urandom_range(0, 1));
			w.acl_id = 16'($urandom_range(0, 65535));
		end else begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				w.op = OP_CHECK;
			end else if (r < 75) begin
				w.op = OP_SET_XOR;
			end else if (r < 95) begin
				w.op = OP_SET_OR;
			end else begin
				w.op = OP_SET_ALT;
			end
			w.inode = inode_pool[$urandom_range(0, 7)];
			w.file_mode = 16'($urandom_range(0, 65535));
			w.owner_uid = ($urandom_range(0, 29) == 0) ? ID_UNKNOWN : uid_pool[$urandom_range(0, 5)];
			w.owner_gid = ($urandom_range(0, 29) == 0) ? ID_UNKNOWN : gid_pool[$urandom_range(0, 5)];
			r = $urandom_range(0, 99);
			if (r < 15) begin
				w.caller_uid = ROOT_UID;
			end else if (r < 50) begin
				w.caller_uid = w.owner_uid;
			end else begin
				w.caller_uid = uid_pool[$urandom_range(0, 5)];
			end
			w.caller_gid = gid_pool[$urandom_range(0, 5)];
			w.in_supp_group = ($urandom_range(0, 4) == 0);
			w.readonly_fs = ($urandom_range(0, 6) == 0);
			w.perms = 3'($urandom_range(0, 7));
			w.acl_kind = 1'($urandom_range(0, 1));
			w.acl_id = w.acl_kind ? uid_pool[$urandom_range(0, 5)] : gid_pool[$urandom_range(0, 5)];
		end
		return w;
	endfunction

	task automatic push_word(input acl_word_t w);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= w.op;
		req_ch.inode <= w.inode;
		req_ch.file_mode <= w.file_mode;
		req_ch.owner_uid <= w.owner_uid;
		req_ch.owner_gid <= w.owner_gid;
		req_ch.caller_uid <= w.caller_uid;
		req_ch.caller_gid <= w.caller_gid;
		req_ch.in_supp_group <= w.in_supp_group;
		req_ch.readonly_fs <= w.readonly_fs;
		req_ch.perms <= w.perms;
		req_ch.acl_kind <= w.acl_kind;
		req_ch.acl_id <= w.acl_id;
		do begin
			@(posedge clk);
		end while (req_ch.ready !== 1'b1);
	endtask

	initial begin
		arst_n = 1'b0;
		idle_on = 1'b1;
		stall_asks = 0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_CHECK;
		req_ch.inode = '0;
		req_ch.file_mode = '0;
		req_ch.owner_uid = '0;
		req_ch.owner_gid = '0;
		req_ch.caller_uid = '0;
		req_ch.caller_gid = '0;
		req_ch.in_supp_group = 1'b0;
		req_ch.readonly_fs = 1'b0;
		req_ch.perms = '0;
		req_ch.acl_kind = 1'b0;
		req_ch.acl_id = '0;
		inode_pool[0] = 32'h0000_0000;
		inode_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < 8; i++) begin
			inode_pool[i] = $urandom;
		end
		for (int i = 0; i < 6; i++) begin
			uid_pool[i] = 16'(100 + i);
			gid_pool[i] = 16'(200 + i);
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// unknown owner and unknown group
		push_word(mk_word(OP_CHECK, 32'h0, 16'h81A4, ID_UNKNOWN, 200, 100, 200, 0, 0, 4, 0, 0));
		push_word(mk_word(OP_CHECK, 32'h0, 16'h81A4, 100, ID_UNKNOWN, 100, 200, 0, 0, 4, 0, 0));
		// root: directory without x, file without x, file with other x only
		push_word(mk_word(OP_CHECK, 32'h0, 16'h4000, 100, 200, ROOT_UID, 200, 0, 0, 7, 0, 0));
		push_word(mk_word(OP_CHECK, 32'h0, 16'h81B6, 100, 200, ROOT_UID, 200, 0, 0, 7, 0, 0));
		push_word(mk_word(OP_CHECK, 32'h0, 16'h8001, 100, 200, ROOT_UID, 200, 0, 1, 7, 0, 0));
		// owner, group by gid, group by supplementary, other on a read-only mount
		push_word(mk_word(OP_CHECK, 32'h0, 16'h81ED, 100, 200, 100, 201, 0, 0, 7, 0, 0));
		push_word(mk_word(OP_CHECK, 32'h0, 16'h81ED, 100, 200, 101, 200, 0, 0, 2, 0, 0));
		push_word(mk_word(OP_CHECK, 32'h0, 16'h81ED, 100, 200, 101, 201, 1, 0, 5, 0, 0));
		push_word(mk_word(OP_CHECK, 32'h0, 16'hFFFF, 100, 200, 101, 201, 0, 1, 7, 0, 0));
		// set refused: not owner, read-only
		push_word(mk_word(OP_SET_XOR, 32'h0, 16'h0, 100, 200, 101, 200, 0, 0, 7, 1, 101));
		push_word(mk_word(OP_SET_XOR, 32'h0, 16'h0, 100, 200, 100, 200, 0, 1, 7, 1, 101));
		// append a user entry, hit it, then xor, or and the spare op code
		push_word(mk_word(OP_SET_XOR, 32'h0, 16'h0, 100, 200, 100, 200, 0, 0, 2, 1, 101));
		push_word(mk_word(OP_CHECK, 32'h0, 16'h8004, 100, 200, 101, 201, 0, 0, 6, 0, 0));
		push_word(mk_word(OP_SET_XOR, 32'h0, 16'h0, 100, 200, 100, 200, 0, 0, 6, 1, 101));
		push_word(mk_word(OP_SET_OR, 32'h0, 16'h0, 100, 200, ROOT_UID, 200, 0, 0, 1, 1, 101));
		push_word(mk_word(OP_SET_ALT, 32'h0, 16'h0, 100, 200, 100, 200, 0, 0, 2, 1, 101));
		// group entry with id zero and user entry with the all-ones id
		push_word(mk_word(OP_SET_OR, 32'hFFFF_FFFF, 16'h0, 100, 200, 100, 200, 0, 0, 7, 0, 16'h0));
		push_word(mk_word(OP_CHECK, 32'hFFFF_FFFF, 16'h0, 100, 200, 102, 16'h0, 0, 0, 7, 0, 0));
		push_word(mk_word(OP_SET_XOR, 32'hFFFF_FFFF, 16'h0, 100, 200, 100, 200, 0, 0, 0, 1,
			16'hFFFF));
		push_word(mk_word(OP_CHECK, 32'hFFFF_FFFF, 16'h0, 100, 200, 16'hFFFF, 5, 0, 0, 0, 0, 0));
		// root skips the table, read-only read, kind must match
		push_word(mk_word(OP_CHECK, 32'hFFFF_FFFF, 16'h0, 100, 200, ROOT_UID, 16'h0, 0, 0, 6, 0, 0));
		push_word(mk_word(OP_CHECK, 32'h0, 16'h81A4, 100, 200, 102, 201, 0, 1, 4, 0, 0));
		push_word(mk_word(OP_CHECK, 32'h0, 16'h8000, 100, 101, 102, 101, 0, 0, 0, 0, 0));

		// sender pauses until every result has come back
		@(negedge clk);
		req_ch.valid <= 1'b0;
		wait (outstanding == 0);

		repeat (500) push_word(random_word());
		stall_asks++;
		repeat (30) push_word(random_word());
		repeat (330) push_word(random_word());
		idle_on = 1'b0;
		repeat (160) push_word(random_word());

		@(negedge clk);
		req_ch.valid <= 1'b0;
		wait (outstanding == 0);
		repeat (aclpt_pkg::ENTRIES_DEF + 10) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
